/* hw/rtl/e2q_pkg.sv */
// Shared widths, fixed-point constants and the CORDIC arctangent table
// for the Euler-angle to quaternion pipeline. No dependencies.
package e2q_pkg;

  // CORDIC datapath, Q.30 in 34 bits
  localparam int CW    = 34;
  // sine and cosine after rounding, Q.20
  localparam int CS_W  = 22;
  // pair products (Q.40) and their split for the triple products
  localparam int PR_W  = 44;
  localparam int PL_W  = 22;
  localparam int TP_W  = 64;
  // quaternion before normalisation, Q.30
  localparam int Q_W   = 33;
  localparam int MAG_W = 32;
  // squared length, root and root remainder
  localparam int N2_W  = 64;
  localparam int RT_W  = 32;
  localparam int RM_W  = 36;

  // angle lanes
  localparam int LANE_X = 0;
  localparam int LANE_Y = 1;
  localparam int LANE_Z = 2;

  // pair products
  localparam int PR_CXCY = 0;
  localparam int PR_SXSY = 1;
  localparam int PR_SXCY = 2;
  localparam int PR_CXSY = 3;

  // multiplier of the triple products
  localparam int MUL_CZ = 0;
  localparam int MUL_SZ = 1;

  // quaternion components
  localparam int COMP_W = 0;
  localparam int COMP_I = 1;
  localparam int COMP_J = 2;
  localparam int COMP_K = 3;

  localparam logic signed [CW-1:0] PI_Q30      = 34'sd3373259426;
  localparam logic signed [CW-1:0] HALF_PI_Q30 = 34'sd1686629713;
  localparam logic signed [CW-1:0] CORDIC_X0   = 34'sd652032874;
  localparam logic signed [CW-1:0] RND10       = 34'sd512;
  localparam logic signed [TP_W-1:0] RND30     = 64'sd536870912;

  // arctangents of 2^-i, Q.30
  localparam logic [31:0] ATAN_Q30 [32] = '{
    32'h3243F6A8, 32'h1DAC6705, 32'h0FADBAFC, 32'h07F56EA6, 32'h03FEAB76, 32'h01FFD55B,
    32'h00FFFAAA, 32'h007FFF55, 32'h003FFFEA, 32'h001FFFFD, 32'h000FFFFF, 32'h0007FFFF,
    32'h0003FFFF, 32'h0001FFFF, 32'h0000FFFF, 32'h00007FFF, 32'h00003FFF, 32'h00001FFF,
    32'h00000FFF, 32'h000007FF, 32'h000003FF, 32'h000001FF, 32'h000000FF, 32'h0000007F,
    32'h0000003F, 32'h0000001F, 32'h0000000F, 32'h00000008, 32'h00000004, 32'h00000002,
    32'h00000001, 32'h00000000
  };

endpackage

/* hw/rtl/euler_to_quaternion.sv */
// Euler angles to unit quaternion, fully pipelined.
// Depends on e2q_pkg for widths, constants and the arctangent table.
// Three angles (radians, signed Q3.(ANGLE_WIDTH-3)) arrive as one word on the
// slave stream; one unit quaternion (signed Q1.OUT_FRAC_BITS) leaves as one
// word on the master stream for every word taken. The block takes one word
// every cycle while the output is not held. The pipeline holds one fold stage,
// one CORDIC stage per step for the three half angles, a rounding stage,
// four stages of products and rounding, a square stage, a sum stage,
// 32 stages of the digit-by-digit square root, a dividend stage,
// OUT_FRAC_BITS+1 stages of restoring division and the output register.
// Every stage moves on together: while a finished word waits at the output
// with tready low, the whole pipeline and the slave side hold. A quaternion of
// zero length (not reachable from any angle) leaves as w = 1, i = j = k = 0.
// The block keeps no state between words; it has no configuration.
module euler_to_quaternion
  import e2q_pkg::*;
#(
  parameter int ANGLE_WIDTH   = 16,
  parameter int OUT_FRAC_BITS = 14,
  parameter int CORDIC_STEPS  = 16,
  localparam int OW           = OUT_FRAC_BITS + 2,
  localparam int IN_TDATA_W   = ((3 * ANGLE_WIDTH + 7) / 8) * 8,
  localparam int OUT_TDATA_W  = ((4 * OW + 7) / 8) * 8
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  // angle_x, angle_y, angle_z from the lowest bit up
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  // quat_w, quat_i, quat_j, quat_k from the lowest bit up
  output logic [OUT_TDATA_W-1:0] m_axis_tdata
);

  localparam int ANG_SHIFT = 32 - ANGLE_WIDTH;
  localparam int NS        = CORDIC_STEPS;
  localparam int QD_W      = OUT_FRAC_BITS + 1;
  localparam int DW        = MAG_W + QD_W;
  localparam logic [QD_W-1:0]      QLIM = QD_W'(1) << OUT_FRAC_BITS;
  localparam logic signed [OW-1:0] QMAX = OW'(QLIM);
  localparam logic signed [OW-1:0] QMIN = -QMAX;

  // one enable for the whole pipeline: advance unless the output word is stuck
  logic adv;
  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;

  // ---------------------------------------------------------------------------
  // Fold: form the Q2.30 half angle and fold it into [-pi/2, pi/2]
  // ---------------------------------------------------------------------------
  logic signed [ANGLE_WIDTH-1:0] ang   [3];
  logic signed [CW-1:0]          h_in  [3];
  logic signed [CW-1:0]          z_in  [3];
  logic                          neg_in[3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      ang[l] = s_axis_tdata[l*ANGLE_WIDTH +: ANGLE_WIDTH];
      h_in[l] = CW'(ang[l]) <<< ANG_SHIFT;
      if (h_in[l] > HALF_PI_Q30) begin
        z_in[l]   = h_in[l] - PI_Q30;
        neg_in[l] = 1'b1;
      end else if (h_in[l] < -HALF_PI_Q30) begin
        z_in[l]   = h_in[l] + PI_Q30;
        neg_in[l] = 1'b1;
      end else begin
        z_in[l]   = h_in[l];
        neg_in[l] = 1'b0;
      end
    end
  end

  // CORDIC registers: index 0 is the fold stage, index i+1 follows step i
  logic                 cv  [0:NS];
  logic signed [CW-1:0] cx  [0:NS][3];
  logic signed [CW-1:0] cy  [0:NS][3];
  logic signed [CW-1:0] cz  [0:NS][3];
  logic                 cneg[0:NS][3];

  always_ff @(posedge clk) begin
    if (rst) begin
      cv[0] <= 1'b0;
    end else if (adv) begin
      cv[0] <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        cx[0][l]   <= CORDIC_X0;
        cy[0][l]   <= '0;
        cz[0][l]   <= z_in[l];
        cneg[0][l] <= neg_in[l];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // CORDIC rotation, one step per stage; shift and arctangent fixed per stage
  // ---------------------------------------------------------------------------
  for (genvar i = 0; i < NS; i++) begin : g_cordic
    localparam logic signed [CW-1:0] AT = CW'(ATAN_Q30[i]);

    always_ff @(posedge clk) begin
      if (rst) begin
        cv[i+1] <= 1'b0;
      end else if (adv) begin
        cv[i+1] <= cv[i];
      end
    end

    for (genvar l = 0; l < 3; l++) begin : g_lane
      logic signed [CW-1:0] dx, dy;
      assign dx = cy[i][l] >>> i;
      assign dy = cx[i][l] >>> i;

      always_ff @(posedge clk) begin
        if (adv) begin
          cneg[i+1][l] <= cneg[i][l];
          if (!cz[i][l][CW-1]) begin
            cx[i+1][l] <= cx[i][l] - dx;
            cy[i+1][l] <= cy[i][l] + dy;
            cz[i+1][l] <= cz[i][l] - AT;
          end else begin
            cx[i+1][l] <= cx[i][l] + dx;
            cy[i+1][l] <= cy[i][l] - dy;
            cz[i+1][l] <= cz[i][l] + AT;
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Undo the fold and round sine and cosine to Q.20
  // ---------------------------------------------------------------------------
  logic                   rv;
  logic signed [CS_W-1:0] rs[3];
  logic signed [CS_W-1:0] rc[3];
  logic signed [CW-1:0]   xn[3];
  logic signed [CW-1:0]   yn[3];

  always_comb begin
    for (int l = 0; l < 3; l++) begin
      xn[l] = cneg[NS][l] ? -cx[NS][l] : cx[NS][l];
      yn[l] = cneg[NS][l] ? -cy[NS][l] : cy[NS][l];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      rv <= 1'b0;
    end else if (adv) begin
      rv <= cv[NS];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int l = 0; l < 3; l++) begin
        rc[l] <= CS_W'((xn[l] + RND10) >>> 10);
        rs[l] <= CS_W'((yn[l] + RND10) >>> 10);
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Products: pairs of x and y, then the z factor in two partial products
  // ---------------------------------------------------------------------------
  logic                   p1v, p2v, p3v;
  logic signed [PR_W-1:0] pr  [4];
  logic signed [CS_W-1:0] p1zc[2];
  logic signed [PR_W-1:0] pph [2][4];
  logic signed [PR_W:0]   ppl [2][4];
  logic signed [TP_W-1:0] tp  [2][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      p1v <= 1'b0;
      p2v <= 1'b0;
      p3v <= 1'b0;
    end else if (adv) begin
      p1v <= rv;
      p2v <= p1v;
      p3v <= p2v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      pr[PR_CXCY]  <= rc[LANE_X] * rc[LANE_Y];
      pr[PR_SXSY]  <= rs[LANE_X] * rs[LANE_Y];
      pr[PR_SXCY]  <= rs[LANE_X] * rc[LANE_Y];
      pr[PR_CXSY]  <= rc[LANE_X] * rs[LANE_Y];
      p1zc[MUL_CZ] <= rc[LANE_Z];
      p1zc[MUL_SZ] <= rs[LANE_Z];
      for (int m = 0; m < 2; m++) begin
        for (int p = 0; p < 4; p++) begin
          pph[m][p] <= p1zc[m] * $signed(pr[p][PR_W-1:PL_W]);
          ppl[m][p] <= p1zc[m] * $signed({1'b0, pr[p][PL_W-1:0]});
          tp[m][p]  <= (TP_W'(pph[m][p]) <<< PL_W) + TP_W'(ppl[m][p]);
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Combine into the quaternion and round to Q.30
  // ---------------------------------------------------------------------------
  logic                   p4v;
  logic signed [TP_W-1:0] qs[4];
  logic signed [Q_W-1:0]  qr[4];

  always_comb begin
    qs[COMP_W] = tp[MUL_CZ][PR_CXCY] + tp[MUL_SZ][PR_SXSY];
    qs[COMP_I] = tp[MUL_SZ][PR_CXCY] - tp[MUL_CZ][PR_SXSY];
    qs[COMP_J] = tp[MUL_CZ][PR_SXCY] + tp[MUL_SZ][PR_CXSY];
    qs[COMP_K] = tp[MUL_CZ][PR_CXSY] - tp[MUL_SZ][PR_SXCY];
  end

  logic signed [Q_W-1:0] q4[4];

  always_ff @(posedge clk) begin
    if (rst) begin
      p4v <= 1'b0;
    end else if (adv) begin
      p4v <= p3v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        q4[c] <= Q_W'((qs[c] + RND30) >>> 30);
      end
    end
  end

  assign qr = q4;

  // ---------------------------------------------------------------------------
  // Magnitudes and squares, then the squared length
  // ---------------------------------------------------------------------------
  logic              q1v;
  logic [MAG_W-1:0]  q1m[4];
  logic              q1s[4];
  logic [N2_W-1:0]   q1sq[4];
  logic [MAG_W-1:0]  qa [4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      qa[c] = MAG_W'(qr[c][Q_W-1] ? -qr[c] : qr[c]);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      q1v <= 1'b0;
    end else if (adv) begin
      q1v <= p4v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      for (int c = 0; c < 4; c++) begin
        q1m[c]  <= qa[c];
        q1s[c]  <= qr[c][Q_W-1];
        q1sq[c] <= qa[c] * qa[c];
      end
    end
  end

  // square root registers: index 0 holds the sum, index k+1 follows digit k
  logic             sv   [0:RT_W];
  logic [N2_W-1:0]  sr_n [0:RT_W];
  logic [RM_W-1:0]  sr_rm[0:RT_W];
  logic [RT_W-1:0]  sr_rt[0:RT_W];
  logic [MAG_W-1:0] sm   [0:RT_W][4];
  logic             ss   [0:RT_W][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      sv[0] <= 1'b0;
    end else if (adv) begin
      sv[0] <= q1v;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sr_n[0]  <= q1sq[0] + q1sq[1] + q1sq[2] + q1sq[3];
      sr_rm[0] <= '0;
      sr_rt[0] <= '0;
      for (int c = 0; c < 4; c++) begin
        sm[0][c] <= q1m[c];
        ss[0][c] <= q1s[c];
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Floor square root, one result bit per stage
  // ---------------------------------------------------------------------------
  for (genvar k = 0; k < RT_W; k++) begin : g_sqrt
    logic [RM_W-1:0] r2, tr;
    logic            ge;

    assign r2 = {sr_rm[k][RM_W-3:0], sr_n[k][N2_W-1 -: 2]};
    assign tr = RM_W'({sr_rt[k], 2'b01});
    assign ge = r2 >= tr;

    always_ff @(posedge clk) begin
      if (rst) begin
        sv[k+1] <= 1'b0;
      end else if (adv) begin
        sv[k+1] <= sv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        sr_n[k+1]  <= sr_n[k] << 2;
        sr_rm[k+1] <= ge ? r2 - tr : r2;
        sr_rt[k+1] <= {sr_rt[k][RT_W-2:0], ge};
        for (int c = 0; c < 4; c++) begin
          sm[k+1][c] <= sm[k][c];
          ss[k+1][c] <= ss[k][c];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Rounded division: dividend = |q| * 2^F + length/2, one quotient bit a stage
  // ---------------------------------------------------------------------------
  logic [DW-1:0] dsum[4];

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      dsum[c] = (DW'(sm[RT_W][c]) << OUT_FRAC_BITS) + DW'(sr_rt[RT_W] >> 1);
    end
  end

  logic             dv   [0:QD_W];
  logic [RT_W-1:0]  dnorm[0:QD_W];
  logic [MAG_W-1:0] drem [0:QD_W][4];
  logic [QD_W-1:0]  dlow [0:QD_W][4];
  logic [QD_W-1:0]  dquo [0:QD_W][4];
  logic             dsg  [0:QD_W][4];

  always_ff @(posedge clk) begin
    if (rst) begin
      dv[0] <= 1'b0;
    end else if (adv) begin
      dv[0] <= sv[RT_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      dnorm[0] <= sr_rt[RT_W];
      for (int c = 0; c < 4; c++) begin
        drem[0][c] <= dsum[c][DW-1 -: MAG_W];
        dlow[0][c] <= dsum[c][QD_W-1:0];
        dquo[0][c] <= '0;
        dsg[0][c]  <= ss[RT_W][c];
      end
    end
  end

  for (genvar k = 0; k < QD_W; k++) begin : g_div
    logic [MAG_W:0] cand[4];
    logic           ge  [4];

    always_comb begin
      for (int c = 0; c < 4; c++) begin
        cand[c] = {drem[k][c], dlow[k][c][QD_W-1]};
        ge[c]   = cand[c] >= {1'b0, dnorm[k]};
      end
    end

    always_ff @(posedge clk) begin
      if (rst) begin
        dv[k+1] <= 1'b0;
      end else if (adv) begin
        dv[k+1] <= dv[k];
      end
    end

    always_ff @(posedge clk) begin
      if (adv) begin
        dnorm[k+1] <= dnorm[k];
        for (int c = 0; c < 4; c++) begin
          drem[k+1][c] <= ge[c] ? MAG_W'(cand[c] - {1'b0, dnorm[k]}) : cand[c][MAG_W-1:0];
          dlow[k+1][c] <= dlow[k][c] << 1;
          dquo[k+1][c] <= {dquo[k][c][QD_W-2:0], ge[c]};
          dsg[k+1][c]  <= dsg[k][c];
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Saturate, restore the sign, and hold the word at the output
  // ---------------------------------------------------------------------------
  logic [QD_W-1:0]      sat[4];
  logic signed [OW-1:0] res[4];
  logic signed [OW-1:0] quat[4];
  logic                 zero_len;

  assign zero_len = dnorm[QD_W] == '0;

  always_comb begin
    for (int c = 0; c < 4; c++) begin
      sat[c] = (dquo[QD_W][c] > QLIM) ? QLIM : dquo[QD_W][c];
      res[c] = dsg[QD_W][c] ? -OW'(sat[c]) : OW'(sat[c]);
      if (zero_len) begin
        res[c] = (c == COMP_W) ? QMAX : '0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_axis_tvalid <= 1'b0;
    end else if (adv) begin
      m_axis_tvalid <= dv[QD_W];
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      quat <= res;
    end
  end

  assign m_axis_tdata = OUT_TDATA_W'({quat[COMP_K], quat[COMP_J], quat[COMP_I], quat[COMP_W]});

  // ---------------------------------------------------------------------------
  // Checks
  // ---------------------------------------------------------------------------
  logic out_in_range;

  always_comb begin
    out_in_range = 1'b1;
    for (int c = 0; c < 4; c++) begin
      if (quat[c] > QMAX || quat[c] < QMIN) begin
        out_in_range = 1'b0;
      end
    end
  end

  // reset drops any word in flight
  a_reset_empty: assert property (@(posedge clk) rst |=> !m_axis_tvalid)
    else $error("output word valid straight after reset");

  // a delivered quaternion stays within the unit range
  a_out_range: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid |-> out_in_range)
    else $error("quaternion component outside unit range");

  // no component can exceed the length, so the quotient never needs clamping
  a_quo_bound: assert property (@(posedge clk) disable iff (rst)
    (dv[QD_W] && !zero_len) |->
      (dquo[QD_W][COMP_W] <= QLIM && dquo[QD_W][COMP_I] <= QLIM &&
       dquo[QD_W][COMP_J] <= QLIM && dquo[QD_W][COMP_K] <= QLIM))
    else $error("normalised component above one");

endmodule

/* tb/sv/euler_to_quaternion_tb.sv */
// Self-checking testbench for euler_to_quaternion: drives angle words on the
// slave stream, predicts each unit quaternion bit for bit and checks the
// master stream in order. Depends on e2q_pkg and the euler_to_quaternion RTL.
module euler_to_quaternion_tb
  import e2q_pkg::*;
();

  localparam int AW    = 16;
  localparam int FRAC  = 14;
  localparam int STEPS = 16;
  localparam int OW    = FRAC + 2;
  localparam int IN_W  = ((3 * AW + 7) / 8) * 8;
  localparam int OUT_W = ((4 * OW + 7) / 8) * 8;
  localparam int LATENCY = STEPS + FRAC + 43;

  typedef struct packed {
    logic [AW-1:0] az;
    logic [AW-1:0] ay;
    logic [AW-1:0] ax;
  } angles_t;

  typedef struct packed {
    logic [OW-1:0] k;
    logic [OW-1:0] j;
    logic [OW-1:0] i;
    logic [OW-1:0] w;
  } quat_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_axis_tvalid = 1'b0;
  logic s_axis_tready;
  logic [IN_W-1:0] s_axis_tdata = '0;
  logic m_axis_tvalid;
  logic m_axis_tready = 1'b0;
  logic [OUT_W-1:0] m_axis_tdata;

  euler_to_quaternion uut (
    .clk(clk), .rst(rst),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  angles_t pending_angles[$];
  quat_t   expected_quats[$];
  int      fail_count = 0;
  int      send_idle_pct = 11;
  int      recv_idle_pct = 66;
  bit      recv_hold = 1'b0;

  initial begin
    forever #4 clk = ~clk;
  end

  // Sine and cosine of half an angle, Q.20, by folded CORDIC in Q.30.
  function automatic void half_sin_cos(input logic [AW-1:0] a,
                                       output longint s, output longint c);
    longint h, x, y, z, dx, dy, t;
    bit neg;
    h = longint'($signed(a)) * (longint'(1) << (32 - AW));
    neg = 1'b0;
    x = longint'(CORDIC_X0);
    y = 0;
    if (h > longint'(HALF_PI_Q30)) begin
      h -= longint'(PI_Q30); neg = 1'b1;
    end else if (h < -longint'(HALF_PI_Q30)) begin
      h += longint'(PI_Q30); neg = 1'b1;
    end
    z = h;
    for (int n = 0; n < STEPS; n++) begin
      dx = y >>> n;
      dy = x >>> n;
      t = longint'(ATAN_Q30[n]);
      if (z >= 0) begin
        x -= dx; y += dy; z -= t;
      end else begin
        x += dx; y -= dy; z += t;
      end
    end
    if (neg) begin
      x = -x; y = -y;
    end
    c = (x + 512) >>> 10;
    s = (y + 512) >>> 10;
  endfunction

  function automatic longint unsigned floor_sqrt(input longint unsigned n);
    longint unsigned r, b;
    r = 0;
    b = longint'(1) << 62;
    while (b > n) b >>= 2;
    while (b != 0) begin
      if (n >= r + b) begin
        n -= r + b; r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  // Divide one component by the length, round half away, saturate to one.
  function automatic logic [OW-1:0] scale_comp(input longint v, input longint unsigned len);
    longint unsigned mag, q;
    mag = (v < 0) ? longint'(-v) : longint'(v);
    q = ((mag << FRAC) + len / 2) / len;
    if (q > (longint'(1) << FRAC)) q = longint'(1) << FRAC;
    if (v < 0) q = -q;
    return q[OW-1:0];
  endfunction

  function automatic quat_t predict_quat(input angles_t a);
    longint sx, cx, sy, cy, sz, cz, cxcy, sxsy, sxcy, cxsy, qw, qi, qj, qk;
    longint unsigned len;
    quat_t r;
    half_sin_cos(a.ax, sx, cx);
    half_sin_cos(a.ay, sy, cy);
    half_sin_cos(a.az, sz, cz);
    cxcy = cx * cy; sxsy = sx * sy; sxcy = sx * cy; cxsy = cx * sy;
    qi = (sz * cxcy - cz * sxsy + (longint'(1) << 29)) >>> 30;
    qj = (cz * sxcy + sz * cxsy + (longint'(1) << 29)) >>> 30;
    qk = (cz * cxsy - sz * sxcy + (longint'(1) << 29)) >>> 30;
    qw = (cz * cxcy + sz * sxsy + (longint'(1) << 29)) >>> 30;
    len = floor_sqrt(qw * qw + qi * qi + qj * qj + qk * qk);
    if (len == 0) begin
      r = '0;
      r.w = OW'(1) << FRAC;
    end else begin
      r.w = scale_comp(qw, len);
      r.i = scale_comp(qi, len);
      r.j = scale_comp(qj, len);
      r.k = scale_comp(qk, len);
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [OW-1:0] got,
                                 input logic [OW-1:0] want);
    $display("mismatch %s: got %0d expected %0d", what, $signed(got), $signed(want));
    fail_count++;
  endtask

  // Driver: hold the word until taken, then advance or idle at random.
  always @(posedge clk) begin
    if (!rst) begin
      if (!s_axis_tvalid || s_axis_tready) begin
        if (pending_angles.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          angles_t a;
          a = pending_angles.pop_front();
          expected_quats.push_back(predict_quat(a));
          s_axis_tdata <= a;
          s_axis_tvalid <= 1'b1;
        end else begin
          s_axis_tvalid <= 1'b0;
        end
      end
    end
  end

  // Monitor: check each word taken against the oldest prediction.
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) begin
        quat_t got, want;
        got = m_axis_tdata[4*OW-1:0];
        if (expected_quats.size() == 0) begin
          report_mismatch("unexpected word quat_w", got.w, '0);
        end else begin
          want = expected_quats.pop_front();
          if (got.w !== want.w) report_mismatch("quat_w", got.w, want.w);
          if (got.i !== want.i) report_mismatch("quat_i", got.i, want.i);
          if (got.j !== want.j) report_mismatch("quat_j", got.j, want.j);
          if (got.k !== want.k) report_mismatch("quat_k", got.k, want.k);
        end
      end
      m_axis_tready <= !recv_hold && ($urandom_range(99) >= recv_idle_pct);
    end
  end

  function automatic angles_t rand_angles();
    angles_t a;
    a.ax = AW'($urandom);
    a.ay = AW'($urandom);
    a.az = AW'($urandom);
    // bias some lanes towards the fold points and the extremes
    if ($urandom_range(7) == 0) a.ax = $urandom_range(1) ? 16'h7FFF : 16'h8000;
    if ($urandom_range(7) == 0) a.ay = AW'(16'd25736 + $urandom_range(4) - 2);
    if ($urandom_range(7) == 0) a.az = AW'(-(16'd25736 + $urandom_range(4) - 2));
    return a;
  endfunction

  task automatic wait_drained();
    while (pending_angles.size() > 0 || s_axis_tvalid || expected_quats.size() > 0)
      @(posedge clk);
  endtask

  initial begin
    // zero angle, extremes, near the +-pi fold (half angle pi/2 = 25736)
    logic [AW-1:0] corner [8] = '{16'h0000, 16'h7FFF, 16'h8000, 16'h0001,
                                  16'hFFFF, 16'd25736, 16'd25737, -16'sd25737};
    for (int n = 0; n < 8; n++) begin
      pending_angles.push_back('{az: corner[n], ay: corner[n], ax: corner[n]});
      pending_angles.push_back('{az: corner[(n+3)%8], ay: corner[(n+5)%8], ax: corner[n]});
    end
    pending_angles.push_back('{az: 16'h5555, ay: 16'hAAAA, ax: 16'h0F0F});
    pending_angles.push_back('{az: 16'hAAAA, ay: 16'h5555, ax: 16'hF0F0});
    repeat (4) @(posedge clk);
    rst <= 1'b0;

    for (int n = 0; n < 400; n++) pending_angles.push_back(rand_angles());
    wait_drained();

    send_idle_pct = 66;
    recv_idle_pct = 11;
    for (int n = 0; n < 400; n++) pending_angles.push_back(rand_angles());
    wait_drained();

    // no idling; a long receiver hold fills the pipeline and stalls the input
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int n = 0; n < 400; n++) pending_angles.push_back(rand_angles());
    repeat (20) @(posedge clk);
    recv_hold = 1'b1;
    repeat (300) @(posedge clk);
    recv_hold = 1'b0;
    wait_drained();
    repeat (LATENCY + 10) @(posedge clk);

    if (fail_count == 0 && expected_quats.size() == 0)
      $display("PASS euler_to_quaternion");
    else
      $display("FAIL euler_to_quaternion");
    $finish;
  end

  initial begin
    #2000000;
    $display("FAIL euler_to_quaternion");
    $finish;
  end

endmodule
